// File: sv/optimizer_param_update_unit_macros.svh
// Assertion macros for the optimizer update block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef OPTIMIZER_PARAM_UPDATE_UNIT_MACROS_SVH
`define OPTIMIZER_PARAM_UPDATE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// check sampled on the rising clock edge, off while reset is high
`define OPU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("optimizer update check failed");
// check sampled on the rising clock edge, also during reset
`define OPU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("optimizer update check failed");
`else
`define OPU_ASSERT(lbl, clk, rst, prop)
`define OPU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/opu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the optimizer update pipeline.
// No dependencies; used by opu_sqrt, opu_div and the top level.
package opu_pkg;

   // data format
   localparam int DATA_W  = 32;
   localparam int VAL_W   = DATA_W - 1;
   localparam int FRAC_W  = 24;
   localparam int LR_W    = 24;
   localparam int BETA_W  = 16;
   localparam int CORR_W  = 28;
   localparam int EPS_W   = 24;
   localparam int MODE_W  = 3;
   localparam int IDX_W   = 3;
   localparam int CSR_W   = 28;
   localparam int UPD_W   = DATA_W + 1;

   // square root unit: root of (x << FRAC_W), x below 2^31
   localparam int ROOT_W     = 28;
   localparam int SQ_IN_W    = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int SQ_PER     = 4;
   localparam int SQ_STAGES  = ROOT_W / SQ_PER;

   // divider: lr * numerator / (root + eps)
   localparam int NUM_W      = 56;
   localparam int DEN_W      = ROOT_W + 1;
   localparam int DIV_PER    = 7;
   localparam int DIV_STAGES = NUM_W / DIV_PER;

   // update rules
   localparam logic [MODE_W-1:0] MODE_SGD      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_MOMENTUM = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RMSPROP  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ADAM     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_AMSGRAD  = 3'd4;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_BETA1 = 3'd1;
   localparam logic [IDX_W-1:0] CSR_BETA2 = 3'd2;
   localparam logic [IDX_W-1:0] CSR_EPS   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_LR    = 3'd4;
   localparam logic [IDX_W-1:0] CSR_BC1   = 3'd5;
   localparam logic [IDX_W-1:0] CSR_BC2   = 3'd6;

   // register reset values
   localparam logic [MODE_W-1:0] MODE_RST  = MODE_ADAM;
   localparam logic [BETA_W-1:0] BETA1_RST = 16'd58982;
   localparam logic [BETA_W-1:0] BETA2_RST = 16'd65470;
   localparam logic [EPS_W-1:0]  EPS_RST   = 24'd1;
   localparam logic [LR_W-1:0]   LR_RST    = 24'd16777;
   localparam logic [CORR_W-1:0] BC1_RST   = 28'd655360;
   localparam logic [CORR_W-1:0] BC2_RST   = 28'd65536000;

   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] gradient;
      logic signed [DATA_W-1:0] first_moment;
      logic [VAL_W-1:0]         second_moment;
      logic [VAL_W-1:0]         max_second_moment;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_weight;
      logic signed [DATA_W-1:0] new_first_moment;
      logic [VAL_W-1:0]         new_second_moment;
      logic [VAL_W-1:0]         new_max_second_moment;
      logic                     saturated;
   } rsp_type;

   // what travels beside the root and divide units
   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] w;
      logic signed [DATA_W-1:0] m_out;
      logic [VAL_W-1:0]         v_out;
      logic [VAL_W-1:0]         vmax_out;
      logic                     neg;
      logic                     clip;
      logic [VAL_W-1:0]         upd_lin;
      logic [NUM_W-1:0]         num;
      logic                     num_zero;
      logic                     den_zero;
   } side_type;

endpackage

// File: sv/opu_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root of (x << FRAC_W), four root bits per stage.
// Depends on opu_pkg.
module opu_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [opu_pkg::VAL_W-1:0]     x_in,
   input  opu_pkg::side_type             side_in,
   output logic [opu_pkg::ROOT_W-1:0]    root_out,
   output opu_pkg::side_type             side_out
);
   import opu_pkg::*;

   typedef struct packed {
      logic [SQ_IN_W-1:0] opnd;
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
      side_type           side;
   } sq_st_type;

   // restoring digit steps, two operand bits per root bit
   function automatic sq_st_type sq_step(sq_st_type s);
      sq_st_type          r;
      logic [REM_W+1:0]   r2;
      logic [REM_W+1:0]   trial;
      r = s;
      for (int j = 0; j < SQ_PER; j++) begin
         r2     = {r.rem, r.opnd[SQ_IN_W-1 -: 2]};
         trial  = {2'b00, r.root, 2'b01};
         r.opnd = {r.opnd[SQ_IN_W-3:0], 2'b00};
         if (r2 >= trial) begin
            r2     = r2 - trial;
            r.root = {r.root[ROOT_W-2:0], 1'b1};
         end else begin
            r.root = {r.root[ROOT_W-2:0], 1'b0};
         end
         r.rem = r2[REM_W-1:0];
      end
      return r;
   endfunction

   sq_st_type st_ff [SQ_STAGES];
   sq_st_type st_in [SQ_STAGES];
   sq_st_type first;

   // operand in Q form, shifted up by the fraction width
   always_comb begin
      first.opnd = SQ_IN_W'({x_in, {FRAC_W{1'b0}}});
      first.rem  = '0;
      first.root = '0;
      first.side = side_in;
   end

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_head
         assign st_in[k] = sq_step(first);
      end else begin : g_body
         assign st_in[k] = sq_step(st_ff[k-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign root_out = st_ff[SQ_STAGES-1].root;
   assign side_out = st_ff[SQ_STAGES-1].side;

endmodule

// File: sv/opu_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, seven quotient bits per stage.
// Depends on opu_pkg; the dividend rides in the sideband.
module opu_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [opu_pkg::DEN_W-1:0]     den_in,
   input  opu_pkg::side_type             side_in,
   output logic [opu_pkg::NUM_W-1:0]     q_out,
   output opu_pkg::side_type             side_out
);
   import opu_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0] nrm;
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] q;
      logic [DEN_W-1:0] den;
      side_type         side;
   } dv_st_type;

   function automatic dv_st_type dv_step(dv_st_type s);
      dv_st_type      r;
      logic [DEN_W:0] r2;
      r = s;
      for (int j = 0; j < DIV_PER; j++) begin
         r2    = {r.rem, r.nrm[NUM_W-1]};
         r.nrm = {r.nrm[NUM_W-2:0], 1'b0};
         if (r2 >= {1'b0, r.den}) begin
            r2  = r2 - {1'b0, r.den};
            r.q = {r.q[NUM_W-2:0], 1'b1};
         end else begin
            r.q = {r.q[NUM_W-2:0], 1'b0};
         end
         r.rem = r2[DEN_W-1:0];
      end
      return r;
   endfunction

   dv_st_type st_ff [DIV_STAGES];
   dv_st_type st_in [DIV_STAGES];
   dv_st_type first;

   always_comb begin
      first.nrm  = side_in.num;
      first.rem  = '0;
      first.q    = '0;
      first.den  = den_in;
      first.side = side_in;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_head
         assign st_in[k] = dv_step(first);
      end else begin : g_body
         assign st_in[k] = dv_step(st_ff[k-1]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign q_out    = st_ff[DIV_STAGES-1].q;
   assign side_out = st_ff[DIV_STAGES-1].side;

endmodule

// File: sv/optimizer_param_update_unit.sv
`timescale 1ns / 1ps
// Optimizer step (SGD, momentum, RMSProp, Adam, AMSGrad) in Q8.24 fixed point.
// Depends on opu_pkg, opu_sqrt, opu_div and the assertion macro header.
//
//   channel  ports                          beat
//   req      req_valid/req_stall/req_data    weight, gradient, moments in
//   rsp      rsp_valid/rsp_stall/rsp_data    updated weight and moments out
//   csr      csr_valid/csr_ready/index/data  one register write
//
// One beat enters per cycle while the output is not stalled; the pipeline has six arithmetic stages,
// seven root stages, the epsilon add, eight divide stages and the output register.
// The whole pipeline moves together; it holds only while the output beat is
// stalled. Reset empties the pipeline and loads the register defaults.
`include "optimizer_param_update_unit_macros.svh"
module optimizer_param_update_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  opu_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output opu_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [opu_pkg::IDX_W-1:0]    csr_index,
   input  logic [opu_pkg::CSR_W-1:0]    csr_wdata
);
   import opu_pkg::*;

   localparam int NST = 6 + SQ_STAGES + 1 + DIV_STAGES + 1;
   localparam logic [BETA_W:0]     Q16_ONE = 17'h10000;
   localparam logic [VAL_W-1:0]    VMAX    = {VAL_W{1'b1}};
   localparam logic signed [DATA_W+2:0] WMAX = 35'sd2147483647;
   localparam logic signed [DATA_W+2:0] WMIN = -35'sd2147483648;
   localparam logic [UPD_W-1:0]    UPD_CAP = {1'b1, {DATA_W{1'b0}}};

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] w;
      logic                     g_neg;
      logic [DATA_W-1:0]        gmag;
      logic signed [DATA_W-1:0] m;
      logic [VAL_W-1:0]         v;
      logic [VAL_W-1:0]         vmax;
      logic signed [48:0]       pm1;
      logic signed [49:0]       pg1;
      logic [63:0]              gsq;
      logic [VAL_W-1:0]         updg;
   } s1_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] w;
      logic                     g_neg;
      logic [DATA_W-1:0]        gmag;
      logic signed [DATA_W-1:0] m;
      logic [VAL_W-1:0]         v;
      logic [VAL_W-1:0]         vmax;
      logic signed [DATA_W-1:0] m_new;
      logic [VAL_W-1:0]         g2;
      logic                     g2_clip;
      logic [VAL_W-1:0]         updg;
   } s2_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] w;
      logic                     g_neg;
      logic [DATA_W-1:0]        gmag;
      logic signed [DATA_W-1:0] m;
      logic [VAL_W-1:0]         v;
      logic [VAL_W-1:0]         vmax;
      logic signed [DATA_W-1:0] m_new;
      logic                     m_neg;
      logic [DATA_W-1:0]        mmag;
      logic [46:0]              pv1;
      logic [47:0]              pv2;
      logic                     g2_clip;
      logic [VAL_W-1:0]         updg;
      logic [VAL_W-1:0]         updm;
      logic [59:0]              pmh;
   } s3_type;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] w;
      logic                     g_neg;
      logic [DATA_W-1:0]        gmag;
      logic signed [DATA_W-1:0] m;
      logic [VAL_W-1:0]         v;
      logic [VAL_W-1:0]         vmax;
      logic signed [DATA_W-1:0] m_new;
      logic                     m_neg;
      logic [DATA_W-1:0]        mmag;
      logic [VAL_W-1:0]         v_new;
      logic [DATA_W-1:0]        mh;
      logic                     mh_clip;
      logic                     g2_clip;
      logic [VAL_W-1:0]         updg;
      logic [VAL_W-1:0]         updm;
   } s4_type;

   typedef struct packed {
      s4_type      b;
      logic [58:0] pvh;
   } s5_type;

   typedef struct packed {
      logic [VAL_W-1:0] x;
      side_type         side;
   } s6_type;

   typedef struct packed {
      logic [DEN_W-1:0] den;
      side_type         side;
   } sd_type;

   // configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [BETA_W-1:0] beta1_ff, beta2_ff;
   logic [EPS_W-1:0]  eps_ff;
   logic [LR_W-1:0]   lr_ff;
   logic [CORR_W-1:0] bc1_ff, bc2_ff;

   logic [NST-1:0] vld_ff, vld_in;
   logic           adv;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   sd_type sd_ff, sd_in;
   rsp_type rsp_ff, rsp_in;

   logic [ROOT_W-1:0] sq_root;
   side_type          sq_side;
   logic [NUM_W-1:0]  dv_q;
   side_type          dv_side;

   // config write port, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RST;
         beta1_ff <= BETA1_RST;
         beta2_ff <= BETA2_RST;
         eps_ff   <= EPS_RST;
         lr_ff    <= LR_RST;
         bc1_ff   <= BC1_RST;
         bc2_ff   <= BC2_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_BETA1: beta1_ff <= csr_wdata[BETA_W-1:0];
            CSR_BETA2: beta2_ff <= csr_wdata[BETA_W-1:0];
            CSR_EPS:   eps_ff   <= csr_wdata[EPS_W-1:0];
            CSR_LR:    lr_ff    <= csr_wdata[LR_W-1:0];
            CSR_BC1:   bc1_ff   <= csr_wdata[CORR_W-1:0];
            CSR_BC2:   bc2_ff   <= csr_wdata[CORR_W-1:0];
            default:   ;
         endcase
      end
   end

   // pipeline flow: everything moves unless the output beat is held
   assign adv       = !vld_ff[NST-1] || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: moment products, gradient square, plain lr * |g|
   always_comb begin
      logic [DATA_W-1:0] ug;
      logic [55:0]       pl;
      ug          = req_data.gradient;
      s1_in.mode  = mode_ff;
      s1_in.w     = req_data.weight;
      s1_in.g_neg = ug[DATA_W-1];
      s1_in.gmag  = ug[DATA_W-1] ? (~ug + 32'd1) : ug;
      s1_in.m     = req_data.first_moment;
      s1_in.v     = req_data.second_moment;
      s1_in.vmax  = req_data.max_second_moment;
      s1_in.pm1   = req_data.first_moment * $signed({1'b0, beta1_ff});
      s1_in.pg1   = req_data.gradient * $signed({1'b0, Q16_ONE - {1'b0, beta1_ff}});
      s1_in.gsq   = s1_in.gmag * s1_in.gmag;
      pl          = s1_in.gmag * lr_ff;
      s1_in.updg  = pl[54:24];
   end

   // stage 2: first moment average (floor of sum / 2^16), clipped g^2
   always_comb begin
      logic signed [50:0] sum;
      sum           = 51'(s1_ff.pm1) + 51'(s1_ff.pg1);
      s2_in.mode    = s1_ff.mode;
      s2_in.w       = s1_ff.w;
      s2_in.g_neg   = s1_ff.g_neg;
      s2_in.gmag    = s1_ff.gmag;
      s2_in.m       = s1_ff.m;
      s2_in.v       = s1_ff.v;
      s2_in.vmax    = s1_ff.vmax;
      s2_in.updg    = s1_ff.updg;
      s2_in.m_new   = sum[47:16];
      s2_in.g2_clip = s1_ff.gsq[63:24] > {9'd0, VMAX};
      s2_in.g2      = s2_in.g2_clip ? VMAX : s1_ff.gsq[54:24];
   end

   // stage 3: second moment products, momentum and Adam numerators
   always_comb begin
      logic [55:0] pl;
      s3_in.mode    = s2_ff.mode;
      s3_in.w       = s2_ff.w;
      s3_in.g_neg   = s2_ff.g_neg;
      s3_in.gmag    = s2_ff.gmag;
      s3_in.m       = s2_ff.m;
      s3_in.v       = s2_ff.v;
      s3_in.vmax    = s2_ff.vmax;
      s3_in.m_new   = s2_ff.m_new;
      s3_in.g2_clip = s2_ff.g2_clip;
      s3_in.updg    = s2_ff.updg;
      s3_in.m_neg   = s2_ff.m_new[DATA_W-1];
      s3_in.mmag    = s3_in.m_neg ? (~s2_ff.m_new + 32'd1) : s2_ff.m_new;
      s3_in.pv1     = s2_ff.v * beta2_ff;
      s3_in.pv2     = s2_ff.g2 * (Q16_ONE - {1'b0, beta2_ff});
      pl            = s3_in.mmag * lr_ff;
      s3_in.updm    = pl[54:24];
      s3_in.pmh     = s3_in.mmag * bc1_ff;
   end

   // stage 4: second moment average, bias corrected first moment
   always_comb begin
      logic [47:0] vs;
      logic [43:0] hs;
      logic [43:0] cap;
      vs            = {1'b0, s3_ff.pv1} + s3_ff.pv2;
      hs            = s3_ff.pmh[59:16];
      cap           = s3_ff.m_neg ? 44'h0_8000_0000 : 44'h0_7FFF_FFFF;
      s4_in.mode    = s3_ff.mode;
      s4_in.w       = s3_ff.w;
      s4_in.g_neg   = s3_ff.g_neg;
      s4_in.gmag    = s3_ff.gmag;
      s4_in.m       = s3_ff.m;
      s4_in.v       = s3_ff.v;
      s4_in.vmax    = s3_ff.vmax;
      s4_in.m_new   = s3_ff.m_new;
      s4_in.m_neg   = s3_ff.m_neg;
      s4_in.mmag    = s3_ff.mmag;
      s4_in.g2_clip = s3_ff.g2_clip;
      s4_in.updg    = s3_ff.updg;
      s4_in.updm    = s3_ff.updm;
      s4_in.v_new   = vs[46:16];
      s4_in.mh_clip = hs > cap;
      s4_in.mh      = s4_in.mh_clip ? cap[DATA_W-1:0] : hs[DATA_W-1:0];
   end

   // stage 5: bias corrected second moment product
   always_comb begin
      s5_in.b   = s4_ff;
      s5_in.pvh = s4_ff.v_new * bc2_ff;
   end

   // stage 6: root operand, divide numerator, per-mode results
   always_comb begin
      logic [42:0]       vs;
      logic              vh_clip;
      logic [VAL_W-1:0]  vh;
      logic [VAL_W-1:0]  vmx;
      logic [DATA_W-1:0] xm;
      logic              mode_v;
      s4_type            b;
      b       = s5_ff.b;
      vs      = s5_ff.pvh[58:16];
      vh_clip = vs > {12'd0, VMAX};
      vh      = vh_clip ? VMAX : vs[VAL_W-1:0];
      vmx     = (b.vmax > b.v_new) ? b.vmax : b.v_new;
      mode_v  = (b.mode == MODE_RMSPROP) || (b.mode == MODE_ADAM) ||
                (b.mode == MODE_AMSGRAD);
      if (b.mode == MODE_RMSPROP) begin
         s6_in.x = b.v_new;
         xm      = b.gmag;
      end else if (b.mode == MODE_ADAM) begin
         s6_in.x = vh;
         xm      = b.mh;
      end else begin
         s6_in.x = vmx;
         xm      = b.mmag;
      end
      s6_in.side.mode     = b.mode;
      s6_in.side.w        = b.w;
      s6_in.side.m_out    = ((b.mode == MODE_MOMENTUM) || (b.mode == MODE_ADAM) ||
                             (b.mode == MODE_AMSGRAD)) ? b.m_new : b.m;
      s6_in.side.v_out    = mode_v ? b.v_new : b.v;
      s6_in.side.vmax_out = (b.mode == MODE_AMSGRAD) ? vmx : b.vmax;
      s6_in.side.neg      = ((b.mode == MODE_SGD) || (b.mode == MODE_RMSPROP)) ?
                            b.g_neg : b.m_neg;
      s6_in.side.clip     = (mode_v && b.g2_clip) ||
                            ((b.mode == MODE_ADAM) && (b.mh_clip || vh_clip));
      s6_in.side.upd_lin  = (b.mode == MODE_SGD) ? b.updg : b.updm;
      s6_in.side.num      = lr_ff * xm;
      s6_in.side.num_zero = (lr_ff == '0) || (xm == '0);
      s6_in.side.den_zero = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   opu_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .x_in     (s6_ff.x),
      .side_in  (s6_ff.side),
      .root_out (sq_root),
      .side_out (sq_side)
   );

   // denominator: root plus epsilon
   always_comb begin
      sd_in.den           = {1'b0, sq_root} + DEN_W'(eps_ff);
      sd_in.side          = sq_side;
      sd_in.side.den_zero = (sd_in.den == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff <= sd_in;
      end
   end

   opu_div u_div (
      .clock    (clock),
      .en       (adv),
      .den_in   (sd_ff.den),
      .side_in  (sd_ff.side),
      .q_out    (dv_q),
      .side_out (dv_side)
   );

   // output stage: pick the update, apply it with saturation
   always_comb begin
      logic [UPD_W-1:0]          upd;
      logic signed [DATA_W+2:0]  w35;
      logic signed [DATA_W+2:0]  u35;
      logic signed [DATA_W+2:0]  ws;
      logic                      wclip;
      if ((dv_side.mode == MODE_SGD) || (dv_side.mode == MODE_MOMENTUM)) begin
         upd = UPD_W'(dv_side.upd_lin);
      end else if (dv_side.num_zero) begin
         upd = '0;
      end else if (dv_side.den_zero || (dv_q > NUM_W'(UPD_CAP))) begin
         upd = UPD_CAP;
      end else begin
         upd = dv_q[UPD_W-1:0];
      end
      w35   = 35'(dv_side.w);
      u35   = $signed({2'b00, upd});
      ws    = dv_side.neg ? (w35 + u35) : (w35 - u35);
      wclip = 1'b0;
      if (ws > WMAX) begin
         ws    = WMAX;
         wclip = 1'b1;
      end else if (ws < WMIN) begin
         ws    = WMIN;
         wclip = 1'b1;
      end
      rsp_in.new_first_moment      = dv_side.m_out;
      rsp_in.new_second_moment     = dv_side.v_out;
      rsp_in.new_max_second_moment = dv_side.vmax_out;
      if (dv_side.mode <= MODE_AMSGRAD) begin
         rsp_in.new_weight = ws[DATA_W-1:0];
         rsp_in.saturated  = dv_side.clip || wclip;
      end else begin
         rsp_in.new_weight = dv_side.w;
         rsp_in.saturated  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data  = rsp_ff;

   // checks
   `OPU_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (vld_ff == '0))
   `OPU_ASSERT(a_accept_enters, clock, reset, (req_valid && !req_stall) |=> vld_ff[0])
   `OPU_ASSERT(a_hold_frozen, clock, reset, req_stall |=> $stable(vld_ff))
   `OPU_ASSERT(a_last_reaches_out, clock, reset, (vld_ff[NST-2] && adv) |=> rsp_valid)

endmodule
